// ===== src/joystick_motor_command_qualifier_top_macros.svh =====
// Assertion macros shared by the joystick motor command qualifier RTL
`ifndef JOYSTICK_MOTOR_COMMAND_QUALIFIER_TOP_MACROS_SVH
`define JOYSTICK_MOTOR_COMMAND_QUALIFIER_TOP_MACROS_SVH

// same-cycle implication
`define JMCQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jmcq assertion failed");

// next-cycle implication
`define JMCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jmcq assertion failed");

`endif

// ===== src/jmcq_pkg.sv =====
// Types, codes and constants of the joystick motor command qualifier
package jmcq_pkg;

  localparam int TICK_WIDTH_DEF = 32;
  localparam int TICK_IN_W      = 32;
  localparam int LOCKOUT_W      = 16;
  localparam int STEP_W         = 6;
  localparam int SPEED_W        = 7;
  localparam int CFG_W          = 16;
  localparam int REG_IDX_W      = 2;
  localparam int BTN_COUNT      = 5;

  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_UP    = 2;
  localparam int BTN_DOWN  = 3;
  localparam int BTN_OK    = 4;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_STOP  = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_LEFT  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_MAX = 2'd2;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET   = 16'd30;
  localparam logic [STEP_W-1:0]    STEP_RESET      = 6'd5;
  localparam logic [SPEED_W-1:0]   SPEED_MAX_RESET = 7'd100;

  typedef struct packed {
    logic [LOCKOUT_W-1:0] lockout_ticks;
    logic [STEP_W-1:0]    speed_step;
    logic [SPEED_W-1:0]   speed_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           motor_dir;
    logic                 motor_on;
    logic [SPEED_W-1:0]   speed_level;
    logic [1:0]           drive_cmd;
    logic                 duty_update;
    logic                 speed_meas_clear;
    logic [BTN_COUNT-1:0] accepted_mask;
  } result_t;

endpackage

// ===== src/jmcq_lane.sv =====
// One button lane: edge detect with tick lockout
module jmcq_lane #(
  parameter int TICK_WIDTH = jmcq_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           capture,
  input  logic                           pressed,
  input  logic [TICK_WIDTH-1:0]          now,
  input  logic [jmcq_pkg::LOCKOUT_W-1:0] lockout,
  output logic                           hit
);
  import jmcq_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > LOCKOUT_W) ? TICK_WIDTH : LOCKOUT_W;

  logic                  prev_pressed;
  logic [TICK_WIDTH-1:0] last_tick;
  logic [TICK_WIDTH-1:0] diff;
  logic [CMP_W-1:0]      diff_x;
  logic [CMP_W-1:0]      lock_x;

  assign diff   = now - last_tick;
  assign diff_x = CMP_W'(diff);
  assign lock_x = CMP_W'(lockout);
  assign hit    = pressed && !prev_pressed && (diff_x > lock_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed <= 1'b0;
      last_tick    <= '0;
    end else if (capture) begin
      prev_pressed <= pressed;
      if (hit) begin
        last_tick <= now;
      end
    end
  end

endmodule

// ===== src/jmcq_merge.sv =====
// Merge stage: apply accepted presses in button order to the drive state
module jmcq_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [jmcq_pkg::BTN_COUNT-1:0] mask,
  input  jmcq_pkg::cfg_t                 cfg,
  output jmcq_pkg::result_t              res
);
  import jmcq_pkg::*;

  logic [1:0]         direction;
  logic               running;
  logic [SPEED_W-1:0] speed_value;

  logic [1:0]         direction_next;
  logic               running_next;
  logic [SPEED_W-1:0] speed_value_next;
  logic [1:0]         cmd;
  logic               duty;
  logic               clr;
  logic [SPEED_W:0]   up_sum;

  always_comb begin
    direction_next   = direction;
    running_next     = running;
    speed_value_next = speed_value;
    cmd              = CMD_NONE;
    duty             = 1'b0;
    clr              = 1'b0;
    if (mask[BTN_RIGHT]) begin
      direction_next = DIR_RIGHT;
      running_next   = 1'b1;
      cmd            = CMD_RIGHT;
      clr            = 1'b1;
    end
    if (mask[BTN_LEFT]) begin
      direction_next = DIR_LEFT;
      running_next   = 1'b1;
      cmd            = CMD_LEFT;
      clr            = 1'b1;
    end
    up_sum = {1'b0, speed_value_next} + (SPEED_W + 1)'(cfg.speed_step);
    if (mask[BTN_UP] && running_next && (up_sum <= {1'b0, cfg.speed_max})) begin
      speed_value_next = up_sum[SPEED_W-1:0];
      duty             = 1'b1;
      clr              = 1'b1;
    end
    if (mask[BTN_DOWN] && running_next &&
        (speed_value_next >= SPEED_W'(cfg.speed_step))) begin
      speed_value_next = speed_value_next - SPEED_W'(cfg.speed_step);
      duty             = 1'b1;
      clr              = 1'b1;
    end
    if (mask[BTN_OK]) begin
      direction_next = DIR_STOP;
      running_next   = 1'b0;
      cmd            = CMD_STOP;
      clr            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= DIR_STOP;
      running     <= 1'b0;
      speed_value <= '0;
    end else if (load) begin
      direction   <= direction_next;
      running     <= running_next;
      speed_value <= speed_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.motor_dir        <= direction_next;
      res.motor_on         <= running_next;
      res.speed_level      <= speed_value_next;
      res.drive_cmd        <= cmd;
      res.duty_update      <= duty;
      res.speed_meas_clear <= clr;
      res.accepted_mask    <= mask;
    end
  end

endmodule

// ===== src/joystick_motor_command_qualifier_top.sv =====
// Joystick motor command qualifier: config, button lanes, merge, output register
// Each input transfer's lane hits are registered in s1_mask, then the merge result is registered at the outputs.
// Throughput: one sample per cycle while the output is not stalled; five lanes qualify all buttons at once.
// Each lane does one TICK_WIDTH-bit wrapping subtract and compare per sample.
// Reset clears history, stops the motor, zeroes speed and loads register defaults.
`include "joystick_motor_command_qualifier_top_macros.svh"

module joystick_motor_command_qualifier_top #(
  parameter int TICK_WIDTH = jmcq_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           right_n,
  input  logic                           left_n,
  input  logic                           up_n,
  input  logic                           down_n,
  input  logic                           ok_n,
  input  logic [jmcq_pkg::TICK_IN_W-1:0] tick_now,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     motor_dir,
  output logic                           motor_on,
  output logic [jmcq_pkg::SPEED_W-1:0]   speed_level,
  output logic [1:0]                     drive_cmd,
  output logic                           duty_update,
  output logic                           speed_meas_clear,
  output logic [jmcq_pkg::BTN_COUNT-1:0] accepted_mask,
  input  logic                           cfg_wen,
  input  logic [jmcq_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [jmcq_pkg::CFG_W-1:0]     cfg_data
);
  import jmcq_pkg::*;

  cfg_t                  cfg;
  logic                  in_xfer;
  logic                  out_load;
  logic                  advance;
  logic                  s1_valid;
  logic [BTN_COUNT-1:0]  s1_mask;
  logic [BTN_COUNT-1:0]  pressed;
  logic [BTN_COUNT-1:0]  hit;
  logic [TICK_WIDTH-1:0] now;
  result_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ticks <= LOCKOUT_RESET;
      cfg.speed_step    <= STEP_RESET;
      cfg.speed_max     <= SPEED_MAX_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LOCKOUT:   cfg.lockout_ticks <= cfg_data[LOCKOUT_W-1:0];
        REG_STEP:      cfg.speed_step    <= cfg_data[STEP_W-1:0];
        REG_SPEED_MAX: cfg.speed_max     <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load = !out_valid || !out_stall;
  assign advance  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  assign now = TICK_WIDTH'(tick_now);
  assign pressed[BTN_RIGHT] = !right_n;
  assign pressed[BTN_LEFT]  = !left_n;
  assign pressed[BTN_UP]    = !up_n;
  assign pressed[BTN_DOWN]  = !down_n;
  assign pressed[BTN_OK]    = !ok_n;

  for (genvar b = 0; b < BTN_COUNT; b++) begin : g_lane
    jmcq_lane #(
      .TICK_WIDTH(TICK_WIDTH)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .capture(in_xfer),
      .pressed(pressed[b]),
      .now    (now),
      .lockout(cfg.lockout_ticks),
      .hit    (hit[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mask <= hit;
    end
  end

  jmcq_merge u_merge (
    .clk (clk),
    .rst (rst),
    .load(advance),
    .mask(s1_mask),
    .cfg (cfg),
    .res (res)
  );

  assign motor_dir        = res.motor_dir;
  assign motor_on         = res.motor_on;
  assign speed_level      = res.speed_level;
  assign drive_cmd        = res.drive_cmd;
  assign duty_update      = res.duty_update;
  assign speed_meas_clear = res.speed_meas_clear;
  assign accepted_mask    = res.accepted_mask;

  `JMCQ_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall, s1_valid)
  `JMCQ_ASSERT_NEXT(a_xfer_fills_stage, clk, rst, in_xfer, s1_valid)
  `JMCQ_ASSERT_NOW(a_on_matches_dir, clk, rst, out_valid, motor_on == (motor_dir != DIR_STOP))
  `JMCQ_ASSERT_NOW(a_duty_clears_meas, clk, rst, out_valid && duty_update, speed_meas_clear)
  `JMCQ_ASSERT_NOW(a_cmd_clears_meas, clk, rst, out_valid && drive_cmd != CMD_NONE, speed_meas_clear)

endmodule

// ===== tb/joystick_motor_command_qualifier_top_test.sv =====
// Self-checking testbench for the joystick motor command qualifier: directed table, then random
module joystick_motor_command_qualifier_top_test;
  import jmcq_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 94;
  localparam int PHASES      = 8;

  localparam logic [BTN_COUNT-1:0] PRESS_RIGHT = 5'b00001;
  localparam logic [BTN_COUNT-1:0] PRESS_LEFT  = 5'b00010;
  localparam logic [BTN_COUNT-1:0] PRESS_UP    = 5'b00100;
  localparam logic [BTN_COUNT-1:0] PRESS_DOWN  = 5'b01000;
  localparam logic [BTN_COUNT-1:0] PRESS_OK    = 5'b10000;

  localparam result_t IDLE_STOP = '{DIR_STOP, 1'b0, 7'd0, CMD_NONE, 1'b0, 1'b0, 5'b0};

  typedef struct {
    logic [BTN_COUNT-1:0] btn;
    logic [TICK_IN_W-1:0] tick;
    bit                   typed;
    result_t              res;
  } drive_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 right_n = 1'b1;
  logic                 left_n = 1'b1;
  logic                 up_n = 1'b1;
  logic                 down_n = 1'b1;
  logic                 ok_n = 1'b1;
  logic [TICK_IN_W-1:0] tick_now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           motor_dir;
  logic                 motor_on;
  logic [SPEED_W-1:0]   speed_level;
  logic [1:0]           drive_cmd;
  logic                 duty_update;
  logic                 speed_meas_clear;
  logic [BTN_COUNT-1:0] accepted_mask;
  logic                 cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // typed expectation travels with the sample it belongs to
  bit      row_typed = 1'b0;
  result_t row_res = '0;

  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int          fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  result_t drive_state_q[$];

  logic [LOCKOUT_W-1:0] lock_cfg;
  logic [STEP_W-1:0]    step_cfg;
  logic [SPEED_W-1:0]   max_cfg;
  logic                 held[BTN_COUNT];
  logic [TICK_IN_W-1:0] last_take[BTN_COUNT];
  logic [1:0]           dir_st;
  logic                 run_st;
  logic [SPEED_W-1:0]   spd_st;

  int unsigned ph_lock[PHASES]  = '{0, 65535, 30, 10, 7, 3, 1, 20};
  int unsigned ph_step[PHASES]  = '{1, 50, 5, 0, 50, 7, 1, 13};
  int unsigned ph_max[PHASES]   = '{100, 100, 100, 1, 100, 20, 1, 100};
  int unsigned ph_send[PHASES]  = '{0, 74, 0, 23, 0, 74, 0, 23};
  int unsigned ph_stall[PHASES] = '{0, 0, 74, 23, 0, 0, 74, 23};

  drive_row_t dir_rows[25] = '{
    '{5'b0, 32'd0, 1'b1, IDLE_STOP},
    '{PRESS_RIGHT, 32'd30, 1'b1, IDLE_STOP},
    '{PRESS_RIGHT, 32'd100, 1'b1, IDLE_STOP},
    '{5'b0, 32'd101, 1'b1, IDLE_STOP},
    '{PRESS_RIGHT, 32'd102, 1'b1,
      '{DIR_RIGHT, 1'b1, 7'd0, CMD_RIGHT, 1'b0, 1'b1, PRESS_RIGHT}},
    '{5'b0, 32'd103, 1'b1, '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b0, 1'b0, 5'b0}},
    '{PRESS_RIGHT, 32'd132, 1'b1, '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b0, 1'b0, 5'b0}},
    '{PRESS_UP, 32'd140, 1'b1, '{DIR_RIGHT, 1'b1, 7'd5, CMD_NONE, 1'b1, 1'b1, PRESS_UP}},
    '{5'b0, 32'd141, 1'b1, '{DIR_RIGHT, 1'b1, 7'd5, CMD_NONE, 1'b0, 1'b0, 5'b0}},
    '{PRESS_DOWN, 32'd150, 1'b1,
      '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b1, 1'b1, PRESS_DOWN}},
    '{5'b0, 32'd151, 1'b1, '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b0, 1'b0, 5'b0}},
    '{PRESS_DOWN, 32'd200, 1'b1,
      '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b0, 1'b0, PRESS_DOWN}},
    '{5'b0, 32'd201, 1'b1, '{DIR_RIGHT, 1'b1, 7'd0, CMD_NONE, 1'b0, 1'b0, 5'b0}},
    '{5'b11111, 32'd300, 1'b1, '{DIR_STOP, 1'b0, 7'd0, CMD_STOP, 1'b1, 1'b1, 5'b11111}},
    '{5'b0, 32'd301, 1'b1, IDLE_STOP},
    '{PRESS_UP, 32'd400, 1'b1, '{DIR_STOP, 1'b0, 7'd0, CMD_NONE, 1'b0, 1'b0, PRESS_UP}},
    '{5'b0, 32'd401, 1'b1, IDLE_STOP},
    '{PRESS_LEFT | PRESS_UP, 32'd500, 1'b1,
      '{DIR_LEFT, 1'b1, 7'd5, CMD_LEFT, 1'b1, 1'b1, PRESS_LEFT | PRESS_UP}},
    '{5'b0, 32'd501, 1'b0, '0},
    '{PRESS_UP, 32'hFFFF_FFFF, 1'b0, '0},
    '{5'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{PRESS_UP, 32'h0000_0010, 1'b0, '0},
    '{5'b0, 32'h0000_0040, 1'b0, '0},
    '{PRESS_UP, 32'h0000_0040, 1'b0, '0},
    '{PRESS_RIGHT | PRESS_LEFT, 32'h8000_0000, 1'b0, '0}
  };

  joystick_motor_command_qualifier_top i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("joystick_motor_command_qualifier_top_test NOT OK");
      $finish;
    end
  end

  function automatic result_t next_drive_state(logic [BTN_COUNT-1:0] btn,
                                               logic [TICK_IN_W-1:0] now);
    result_t              r;
    logic [BTN_COUNT-1:0] take;
    r = '0;
    for (int b = 0; b < BTN_COUNT; b++) begin
      take[b] = 1'b0;
      if (btn[b] && !held[b] && (now - last_take[b]) > lock_cfg) begin
        take[b] = 1'b1;
        last_take[b] = now;
      end
      held[b] = btn[b];
    end
    if (take[BTN_RIGHT]) begin
      dir_st = DIR_RIGHT;
      run_st = 1'b1;
      r.drive_cmd = CMD_RIGHT;
      r.speed_meas_clear = 1'b1;
    end
    if (take[BTN_LEFT]) begin
      dir_st = DIR_LEFT;
      run_st = 1'b1;
      r.drive_cmd = CMD_LEFT;
      r.speed_meas_clear = 1'b1;
    end
    if (take[BTN_UP] && run_st && int'(spd_st) + int'(step_cfg) <= int'(max_cfg)) begin
      spd_st = spd_st + step_cfg;
      r.duty_update = 1'b1;
      r.speed_meas_clear = 1'b1;
    end
    if (take[BTN_DOWN] && run_st && spd_st >= step_cfg) begin
      spd_st = spd_st - step_cfg;
      r.duty_update = 1'b1;
      r.speed_meas_clear = 1'b1;
    end
    if (take[BTN_OK]) begin
      dir_st = DIR_STOP;
      run_st = 1'b0;
      r.drive_cmd = CMD_STOP;
      r.speed_meas_clear = 1'b1;
    end
    r.motor_dir = dir_st;
    r.motor_on = run_st;
    r.speed_level = spd_st;
    r.accepted_mask = take;
    return r;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : drive_check
    result_t              want;
    logic [BTN_COUNT-1:0] btn;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        btn = ~{ok_n, down_n, up_n, left_n, right_n};
        want = next_drive_state(btn, tick_now);
        drive_state_q.push_back(row_typed ? row_res : want);
      end
      if (out_valid && !out_stall) begin
        if (drive_state_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual speed %0d mask %0d",
                   $time, speed_level, accepted_mask);
          fail_cnt++;
        end else begin
          want = drive_state_q.pop_front();
          check_field("motor_dir", want.motor_dir, motor_dir);
          check_field("motor_on", want.motor_on, motor_on);
          check_field("speed_level", want.speed_level, speed_level);
          check_field("drive_cmd", want.drive_cmd, drive_cmd);
          check_field("duty_update", want.duty_update, duty_update);
          check_field("speed_meas_clear", want.speed_meas_clear, speed_meas_clear);
          check_field("accepted_mask", want.accepted_mask, accepted_mask);
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_sample(input logic [BTN_COUNT-1:0] btn,
                             input logic [TICK_IN_W-1:0] tick,
                             input bit typed, input result_t res);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    right_n   <= ~btn[BTN_RIGHT];
    left_n    <= ~btn[BTN_LEFT];
    up_n      <= ~btn[BTN_UP];
    down_n    <= ~btn[BTN_DOWN];
    ok_n      <= ~btn[BTN_OK];
    tick_now  <= tick;
    row_typed <= typed;
    row_res   <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_state_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [LOCKOUT_W-1:0] lk, input logic [STEP_W-1:0] st,
                             input logic [SPEED_W-1:0] mx);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_LOCKOUT;
    cfg_data  <= CFG_W'(lk);
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_data  <= CFG_W'(st);
    @(posedge clk);
    cfg_index <= REG_SPEED_MAX;
    cfg_data  <= CFG_W'(mx);
    @(posedge clk);
    cfg_wen  <= 1'b0;
    lock_cfg = lk;
    step_cfg = st;
    max_cfg  = mx;
  endtask

  initial begin : stimulus
    logic [BTN_COUNT-1:0] btn;
    logic [TICK_IN_W-1:0] tick_run;
    int unsigned          pick;
    lock_cfg = LOCKOUT_RESET;
    step_cfg = STEP_RESET;
    max_cfg  = SPEED_MAX_RESET;
    for (int b = 0; b < BTN_COUNT; b++) begin
      held[b] = 1'b0;
      last_take[b] = '0;
    end
    dir_st = DIR_STOP;
    run_st = 1'b0;
    spd_st = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_sample(dir_rows[i].btn, dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].res);

    tick_run = 32'h8000_0100;
    for (int p = 0; p < PHASES; p++) begin
      load_config(LOCKOUT_W'(ph_lock[p]), STEP_W'(ph_step[p]), SPEED_W'(ph_max[p]));
      send_pct  = ph_send[p];
      stall_pct = ph_stall[p];
      // keep offering while the receiver holds off so the block backs up
      if (p == 2)
        hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 4)
          tick_run = $urandom;
        else if (pick < 60)
          tick_run = tick_run + $urandom_range(lock_cfg / 4 + 3);
        else
          tick_run = tick_run + $urandom_range(2 * lock_cfg + 8, lock_cfg / 2);
        pick = $urandom_range(99);
        if (pick < 45) begin
          btn = '0;
        end else if (pick < 90) begin
          pick = $urandom_range(10);
          btn = (pick < 2) ? PRESS_RIGHT : (pick < 4) ? PRESS_LEFT :
                (pick < 7) ? PRESS_UP : (pick < 10) ? PRESS_DOWN : PRESS_OK;
        end else begin
          btn = BTN_COUNT'($urandom);
        end
        send_sample(btn, tick_run, 1'b0, '0);
      end
    end

    stall_pct = 0;
    drain();
    if (fail_cnt == 0)
      $display("joystick_motor_command_qualifier_top_test OK");
    else
      $display("joystick_motor_command_qualifier_top_test NOT OK");
    $finish;
  end

endmodule
